>>> rtl/scub_pkg.sv
// Shared types and constants for the SPI command bridge.
// No dependencies; used by scub_fifo, spi_command_uart_bridge_top and the bench.
package scub_pkg;

   // Kind of input item (travels on req_tuser)
   typedef enum logic [1:0] {
      ACT_SPI     = 2'd0,
      ACT_HOST_RX = 2'd1,
      ACT_HOST_TX = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // SPI opcodes, command_word[15:12]
   localparam logic [3:0] OP_IDENTIFY = 4'h9;
   localparam logic [3:0] OP_TX_ROOM  = 4'hC;
   localparam logic [3:0] OP_RX_AVAIL = 4'hD;
   localparam logic [3:0] OP_PUSH     = 4'hB;
   localparam logic [3:0] OP_POP      = 4'hA;

   // Reply codes
   localparam logic [15:0] REPLY_NONE  = 16'h0000;
   localparam logic [15:0] REPLY_READY = 16'h0400;
   localparam logic [15:0] REPLY_DATA  = 16'h0800;

   // Identify register
   localparam logic [15:0] ID_RESET     = 16'h0470;
   localparam int          CSR_ADDR_W   = 3;
   localparam logic        CSR_IDX_ID   = 1'b0;

   // FIFO control toward a FIFO
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // FIFO status back to the decoder
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> rtl/scub_fifo.sv
// Byte FIFO with an internal memory and a registered read port.
// Depends on scub_pkg (fifo_ctrl_type, fifo_stat_type).
module scub_fifo
   import scub_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  fifo_ctrl_type ctrl,
   input  logic [7:0]    push_data,
   output logic [7:0]    pop_data,
   output fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [7:0]       mem [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       pop_data_ff;

   // Pointer wrap and fill count
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (ctrl.pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_data   = pop_data_ff;
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full) else $error("push into full FIFO");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty) else $error("pop from empty FIFO");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> (rd_ptr_ff == wr_ptr_ff)) else $error("empty FIFO with pointer gap");
`endif

endmodule

>>> rtl/spi_command_uart_bridge_top.sv
// SPI command bridge top: decode of SPI commands and host events, two byte FIFOs.
// Depends on scub_pkg and scub_fifo.
// The result of an accepted item appears on rsp_* in the next cycle.
// Throughput: one item per cycle; stalls in reset or while a result waits on rsp_tready low.
// Reset: synchronous, active high; empties both FIFOs, drops any pending result
// and loads the identify register with 0x0470. FIFO storage is not cleared.
module spi_command_uart_bridge_top
   import scub_pkg::*;
#(
   parameter int TX_DEPTH = 16,
   parameter int RX_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [15:0] command_word, [23:16] host_byte
   input  logic [1:0]            req_tuser,   // [1:0] action
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [15:0] response_word, [23:16] host_out_byte
   output logic [1:0]            rsp_tuser,   // [0] host_out_valid, [1] receive_overflow
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic          accept;
   action_type    action;
   logic [3:0]    opcode;
   logic [7:0]    push_byte;
   logic [7:0]    host_byte;
   fifo_ctrl_type tx_ctrl, rx_ctrl;
   fifo_stat_type tx_stat, rx_stat;
   logic [7:0]    tx_rd_data, rx_rd_data;
   logic [15:0]   resp_base;
   logic          ovf;

   logic [15:0]   id_word_ff;
   logic          rsp_valid_ff;
   logic [15:0]   resp_base_ff;
   logic          rx_pop_ff;
   logic          tx_pop_ff;
   logic          ovf_ff;

   // Register port: single identify register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         id_word_ff <= ID_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == CSR_IDX_ID)) begin
         id_word_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ID) ? {16'h0000, id_word_ff} : '0;

   // Input handshake
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign action     = action_type'(req_tuser);
   assign opcode     = req_tdata[15:12];
   assign push_byte  = req_tdata[11:4];
   assign host_byte  = req_tdata[23:16];

   // FIFO requests
   assign tx_ctrl.push = accept && (action == ACT_SPI) && (opcode == OP_PUSH) && !tx_stat.full;
   assign tx_ctrl.pop  = accept && (action == ACT_HOST_TX) && !tx_stat.empty;
   assign rx_ctrl.push = accept && (action == ACT_HOST_RX) && !rx_stat.full;
   assign rx_ctrl.pop  = accept && (action == ACT_SPI) && (opcode == OP_POP) && !rx_stat.empty;

   // Command reply that does not depend on popped data
   always_comb begin
      resp_base = REPLY_NONE;
      if (action == ACT_SPI) begin
         case (opcode)
            OP_IDENTIFY: resp_base = id_word_ff;
            OP_TX_ROOM:  resp_base = tx_stat.full   ? REPLY_NONE : REPLY_READY;
            OP_RX_AVAIL: resp_base = rx_stat.empty  ? REPLY_NONE : REPLY_READY;
            OP_PUSH:     resp_base = tx_stat.full   ? REPLY_NONE : REPLY_READY;
            default:     resp_base = REPLY_NONE;
         endcase
      end
   end
   assign ovf = (action == ACT_HOST_RX) && rx_stat.full;

   scub_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tx_ctrl),
      .push_data (push_byte),
      .pop_data  (tx_rd_data),
      .stat      (tx_stat)
   );

   scub_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (rx_ctrl),
      .push_data (host_byte),
      .pop_data  (rx_rd_data),
      .stat      (rx_stat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         resp_base_ff <= resp_base;
         rx_pop_ff    <= rx_ctrl.pop;
         tx_pop_ff    <= tx_ctrl.pop;
         ovf_ff       <= ovf;
      end
   end

   // Popped bytes come straight from the FIFO read registers
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata[15:0] = rx_pop_ff ? (REPLY_DATA | {8'h00, rx_rd_data}) : resp_base_ff;
   assign rsp_tdata[23:16] = tx_pop_ff ? tx_rd_data : 8'h00;
   assign rsp_tuser[0]    = tx_pop_ff;
   assign rsp_tuser[1]    = ovf_ff;

`ifndef ASSERT_OFF
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid) else $error("accepted item left no result");
   a_one_effect: assert property (@(posedge clock) disable iff (reset)
      $countones({tx_ctrl.push, tx_ctrl.pop, rx_ctrl.push, rx_ctrl.pop}) <= 1)
      else $error("one item touched two FIFO ports");
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1])) else $error("take and overflow together");
`endif

endmodule

>>> tb/sv/spi_command_uart_bridge_top_tb.sv
// Self-checking bench for the SPI command bridge: SPI commands and host events go in on
// req_*, a behavioral copy of both FIFOs predicts every result on rsp_*.
// Depends on scub_pkg and spi_command_uart_bridge_top.
module spi_command_uart_bridge_top_tb;
   import scub_pkg::*;

   localparam int TX_DEPTH        = 16;
   localparam int RX_DEPTH        = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 450;

   // register map: identify word at index 0, index 1 has no register behind it
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_ID    = {CSR_IDX_ID, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SPARE = 'd4;
   // an opcode that the decoder does not know
   localparam logic [3:0]            OP_UNUSED      = 4'hE;

   typedef struct packed {
      action_type  act;
      logic [15:0] cmd;
      logic [7:0]  hbyte;
   } bridge_item_type;

   typedef struct packed {
      logic [15:0] reply;
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        overflow;
   } bridge_result_type;

   // DUT connections
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   wire                   req_tready;
   logic [23:0]           req_tdata   = '0;   // [15:0] command_word, [23:16] host_byte
   logic [1:0]            req_tuser   = '0;   // [1:0] action
   wire                   rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   wire  [23:0]           rsp_tdata;          // [15:0] response_word, [23:16] host_out_byte
   wire  [1:0]            rsp_tuser;          // [0] host_out_valid, [1] receive_overflow
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   wire  [31:0]           csr_prdata;
   wire                   csr_pready;

   // bridge model state
   logic [7:0]  tx_mem [TX_DEPTH];
   logic [7:0]  rx_mem [RX_DEPTH];
   int          tx_head   = 0;
   int          tx_fill   = 0;
   int          rx_head   = 0;
   int          rx_fill   = 0;
   logic [15:0] id_shadow = ID_RESET;

   // item traffic bookkeeping
   bridge_item_type   cmd_backlog[$];
   bridge_result_type pending_results[$];
   int                queued_total   = 0;
   int                real_items     = 0;
   int                accepted_total = 0;
   logic              req_took       = 1'b0;
   int                req_idle_pct   = 0;
   int                rsp_idle_pct   = 0;

   // statistics and errors
   int n_results    = 0;
   int n_errors     = 0;
   int tx_drops     = 0;
   int rx_overflows = 0;
   int empty_reads  = 0;
   int cycle_count  = 0;

   spi_command_uart_bridge_top #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Behavioral bridge: applies one item to the model FIFOs, returns its result
   function automatic bridge_result_type bridge_predict(bridge_item_type it);
      bridge_result_type r;
      r = '0;
      case (it.act)
         ACT_SPI: begin
            case (it.cmd[15:12])
               OP_IDENTIFY: r.reply = id_shadow;
               OP_TX_ROOM:  r.reply = (tx_fill < TX_DEPTH) ? REPLY_READY : REPLY_NONE;
               OP_RX_AVAIL: r.reply = (rx_fill != 0) ? REPLY_READY : REPLY_NONE;
               OP_PUSH: begin
                  if (tx_fill < TX_DEPTH) begin
                     tx_mem[(tx_head + tx_fill) % TX_DEPTH] = it.cmd[11:4];
                     tx_fill++;
                     r.reply = REPLY_READY;
                  end else begin
                     tx_drops++;
                  end
               end
               OP_POP: begin
                  if (rx_fill != 0) begin
                     r.reply = REPLY_DATA | {8'h00, rx_mem[rx_head]};
                     rx_head = (rx_head + 1) % RX_DEPTH;
                     rx_fill--;
                  end else begin
                     empty_reads++;
                  end
               end
               default: r.reply = REPLY_NONE;
            endcase
         end
         ACT_HOST_RX: begin
            if (rx_fill < RX_DEPTH) begin
               rx_mem[(rx_head + rx_fill) % RX_DEPTH] = it.hbyte;
               rx_fill++;
            end else begin
               r.overflow = 1'b1;
               rx_overflows++;
            end
         end
         ACT_HOST_TX: begin
            if (tx_fill != 0) begin
               r.out_byte  = tx_mem[tx_head];
               r.out_valid = 1'b1;
               tx_head     = (tx_head + 1) % TX_DEPTH;
               tx_fill--;
            end else begin
               empty_reads++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // Input driver: next item or idle at each falling edge, random result back-pressure
   always @(negedge clock) begin : req_driver
      bridge_item_type next_item;
      if (!reset) begin
         if (!req_tvalid || req_took) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_item  = cmd_backlog.pop_front();
               req_tdata  <= {next_item.hbyte, next_item.cmd};
               req_tuser  <= next_item.act;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor: predict on each accepted item, compare each accepted result
   always @(posedge clock) begin : result_monitor
      bridge_item_type   took;
      bridge_result_type got;
      bridge_result_type want;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         took.act   = action_type'(req_tuser);
         took.cmd   = req_tdata[15:0];
         took.hbyte = req_tdata[23:16];
         pending_results.push_back(bridge_predict(took));
         accepted_total++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.reply     = rsp_tdata[15:0];
         got.out_byte  = rsp_tdata[23:16];
         got.out_valid = rsp_tuser[0];
         got.overflow  = rsp_tuser[1];
         n_results++;
         if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: result with nothing expected, got %h", $time, got);
         end else begin
            want = pending_results.pop_front();
            check_field("response_word", want.reply, got.reply);
            check_field("host_out_byte", 16'(want.out_byte), 16'(got.out_byte));
            check_field("host_out_valid", 16'(want.out_valid), 16'(got.out_valid));
            check_field("receive_overflow", 16'(want.overflow), 16'(got.overflow));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_item(input action_type act, input logic [15:0] cmd,
                             input logic [7:0] hbyte);
      bridge_item_type it;
      it.act   = act;
      it.cmd   = cmd;
      it.hbyte = hbyte;
      cmd_backlog.push_back(it);
      queued_total++;
      if (act != ACT_NONE)
         real_items++;
   endtask

   // SPI word with the given opcode and random payload bits
   function automatic logic [15:0] spi_word(input logic [3:0] op);
      return {op, 12'($urandom)};
   endfunction

   // Random traffic: fill and drain bursts that walk both FIFOs through empty
   // and full, plus mixed well-formed items and raw noise
   task automatic queue_random_traffic(input int target);
      int start;
      int kind;
      int len;
      int pick;
      start = real_items;
      while (real_items - start < target) begin
         kind = $urandom_range(0, 9);
         len  = (kind == 8) ? $urandom_range(1, 4) : $urandom_range(1, 20);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 5);
            case (kind)
               0: queue_item(ACT_SPI, spi_word(pick == 0 ? OP_TX_ROOM : OP_PUSH),
                             8'($urandom));
               1: begin
                  if (pick == 0)
                     queue_item(ACT_SPI, spi_word(OP_TX_ROOM), 8'($urandom));
                  else
                     queue_item(ACT_HOST_TX, 16'($urandom), 8'($urandom));
               end
               2: begin
                  if (pick == 0)
                     queue_item(ACT_SPI, spi_word(OP_RX_AVAIL), 8'($urandom));
                  else
                     queue_item(ACT_HOST_RX, 16'($urandom), 8'($urandom));
               end
               3: queue_item(ACT_SPI, spi_word(pick == 0 ? OP_RX_AVAIL : OP_POP),
                             8'($urandom));
               4, 5, 6, 7: begin
                  case ($urandom_range(0, 6))
                     0: queue_item(ACT_SPI, spi_word(OP_IDENTIFY), 8'($urandom));
                     1: queue_item(ACT_SPI, spi_word(OP_TX_ROOM), 8'($urandom));
                     2: queue_item(ACT_SPI, spi_word(OP_RX_AVAIL), 8'($urandom));
                     3: queue_item(ACT_SPI, spi_word(OP_PUSH), 8'($urandom));
                     4: queue_item(ACT_SPI, spi_word(OP_POP), 8'($urandom));
                     5: queue_item(ACT_HOST_RX, 16'($urandom), 8'($urandom));
                     default: queue_item(ACT_HOST_TX, 16'($urandom), 8'($urandom));
                  endcase
               end
               8: queue_item(action_type'($urandom_range(0, 3)), 16'($urandom),
                             8'($urandom));
               default: queue_item(ACT_SPI, 16'($urandom), 8'($urandom));
            endcase
         end
      end
   endtask

   // Block idle: every queued item taken and every result back
   task automatic wait_drained();
      while (accepted_total != queued_total || pending_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // One register access: setup cycle, then access until pready
   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      logic [31:0] unused;
      csr_access(1'b1, addr, data, unused);
      if (addr == CSR_ADDR_ID)
         id_shadow = data[15:0];
   endtask

   task automatic csr_check_id();
      logic [31:0] rd;
      csr_access(1'b0, CSR_ADDR_ID, '0, rd);
      if (rd !== {16'h0000, id_shadow}) begin
         n_errors++;
         $display("%0t: id_word read mismatch, expected %h, got %h", $time,
                  {16'h0000, id_shadow}, rd);
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset identify, empty and corner cases, field extremes
      req_idle_pct = 33;
      rsp_idle_pct = 53;
      queue_item(ACT_SPI, {OP_IDENTIFY, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_TX_ROOM, 12'hFFF}, 8'hFF);
      queue_item(ACT_SPI, {OP_RX_AVAIL, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_POP, 12'hFFF}, 8'hFF);          // pop from empty
      queue_item(ACT_HOST_TX, 16'hFFFF, 8'hFF);               // take from empty
      queue_item(ACT_HOST_RX, 16'h0000, 8'hFF);
      queue_item(ACT_HOST_RX, 16'hFFFF, 8'h00);
      queue_item(ACT_SPI, {OP_RX_AVAIL, 12'hFFF}, 8'h00);
      queue_item(ACT_SPI, {OP_POP, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_POP, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_PUSH, 8'hFF, 4'hF}, 8'h00);
      queue_item(ACT_SPI, {OP_PUSH, 8'h00, 4'h0}, 8'hFF);
      queue_item(ACT_HOST_TX, 16'h0000, 8'h00);
      queue_item(ACT_HOST_TX, 16'h0000, 8'h00);
      // unused action code leaves the state alone
      queue_item(ACT_NONE, {OP_PUSH, 12'hFFF}, 8'hFF);
      queue_item(ACT_NONE, {OP_POP, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_TX_ROOM, 12'h000}, 8'h00);
      queue_item(ACT_SPI, {OP_RX_AVAIL, 12'h000}, 8'h00);
      // unknown opcodes
      queue_item(ACT_SPI, 16'hFFFF, 8'hFF);
      queue_item(ACT_SPI, 16'h0000, 8'h00);
      queue_item(ACT_SPI, {OP_UNUSED, 12'hABC}, 8'h5A);
      wait_drained();

      // phase 1: all-ones identify word; a write past the map must be ignored
      csr_check_id();
      csr_write(CSR_ADDR_ID, 32'h0000_FFFF);
      csr_write(CSR_ADDR_SPARE, 32'h0000_1234);
      csr_check_id();
      queue_item(ACT_SPI, {OP_IDENTIFY, 12'h000}, 8'h00);
      queue_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      // phase 2: zero identify word, stalls swapped
      req_idle_pct = 53;
      rsp_idle_pct = 33;
      csr_write(CSR_ADDR_ID, 32'hFFFF_0000);
      csr_check_id();
      queue_item(ACT_SPI, {OP_IDENTIFY, 12'hFFF}, 8'h00);
      queue_random_traffic(ITEMS_PER_PHASE);
      wait_drained();

      // phase 3: random identify word, no idling
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      csr_write(CSR_ADDR_ID, $urandom);
      csr_check_id();
      queue_item(ACT_SPI, {OP_IDENTIFY, 12'h000}, 8'h00);
      queue_random_traffic(ITEMS_PER_PHASE);
      wait_drained();
      repeat (4) @(posedge clock);

      $display("Ran %0d items (%0d real) and checked %0d results over four id settings.",
               accepted_total, real_items, n_results);
      $display("Saw %0d dropped pushes, %0d receive overflows, %0d reads from empty FIFOs.",
               tx_drops, rx_overflows, empty_reads);
      if (n_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
